[hw/rtl/smf_pkg.sv]
// ----------------------------------------------------------------------------
// smf_pkg: shared types for the sliding median filter
// Sample type, control and status flags passed between neighboring cells,
// and the fixed widths of the stream and configuration ports.
// ----------------------------------------------------------------------------
package smf_pkg;

  // Width of one sample and of the length register.
  localparam int SampleW = 16;
  localparam int WinCfgW = 4;

  // Length in use after reset.
  localparam logic [WinCfgW-1:0] WinReset = 4'd5;

  typedef logic signed [SampleW-1:0] sample_t;

  // Per-cell flags that travel to the neighboring cells.
  typedef struct packed {
    logic lt;   // stored value is below the incoming sample
    logic del;  // this cell holds the oldest sample of the window
    logic rem;  // the oldest sample sits at this cell or below it
    logic cl;   // the compacted value at this place is below the incoming sample
  } cell_flags_t;

endpackage

[hw/rtl/sliding_median_filter_unit.sv]
// ----------------------------------------------------------------------------
// sliding_median_filter_unit: running median over an odd sliding window
// Every input sample produces the median of the most recent samples.
//
// Input stream s_*: one signed 16-bit sample per transfer in s_tdata.
// Output stream m_*: one signed 16-bit median per transfer in m_tdata.
// Configuration: cfg_we writes cfg_wdata into the 4-bit window length; an
// even length is rounded up to odd and limited to the largest odd value not
// above MAX_WINDOW. Every write clears the window to zeros. Write only while
// no sample is in flight.
// A row of MAX_WINDOW cells keeps the window sorted; each sample transfer
// drops the oldest entry and inserts the new one.
// A sample is first registered in the cells; its median is then loaded from
// the middle cell into the output register, which raises m_tvalid.
// One sample per cycle while the output side accepts.
// A stalled output holds its median in the output register; one more sample
// waits in the cells, then s_tready falls until the output moves.
// Reset clears the window to zeros, sets the length to 5, empties both
// the pending stage and the output register.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [smf_pkg::SampleW-1:0]   s_tdata,   // [15:0] sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [smf_pkg::SampleW-1:0]   m_tdata,   // [15:0] median
  input  logic                          cfg_we,
  input  logic [smf_pkg::WinCfgW-1:0]   cfg_wdata
);

  localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int MaxOdd = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

  logic [smf_pkg::WinCfgW-1:0] window_size;
  logic [smf_pkg::WinCfgW-1:0] odd_req;
  logic [LEN_W-1:0]            len;
  logic [AGE_W-1:0]            len_m1;
  logic [AGE_W-1:0]            mid;
  logic                        pend;
  logic                        load;
  logic                        s_xfer;
  logic [MAX_WINDOW-1:0]       del_vec;
  logic [MAX_WINDOW-1:0]       act_vec;
  smf_pkg::sample_t            new_sample;

  smf_pkg::cell_flags_t        cell_flags [MAX_WINDOW];
  smf_pkg::sample_t            cell_value [MAX_WINDOW];
  logic [AGE_W-1:0]            cell_age   [MAX_WINDOW];
  smf_pkg::sample_t            cell_cval  [MAX_WINDOW];
  logic [AGE_W-1:0]            cell_cage  [MAX_WINDOW];

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= smf_pkg::WinReset;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  // Odd length in use, limited to the row.
  always_comb begin
    odd_req = window_size | smf_pkg::WinCfgW'(1);
    if (int'(odd_req) > MAX_WINDOW) begin
      len = LEN_W'(MaxOdd);
    end else begin
      len = LEN_W'(odd_req);
    end
    len_m1 = AGE_W'(len - 1'b1);
    mid    = AGE_W'(len >> 1);
  end

  // Handshake: one sample may wait in the cells while the output is held.
  assign load     = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || load;
  assign s_xfer   = s_tvalid && s_tready;
  assign new_sample = smf_pkg::sample_t'(s_tdata);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pend <= 1'b0;
    end else if (s_xfer) begin
      pend <= 1'b1;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  // Output register, taken from the middle cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cell_value[mid];
    end
  end

  // Row of cells, sorted ascending from cell 0.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    smf_pkg::cell_flags_t pf;
    smf_pkg::cell_flags_t nf;
    smf_pkg::sample_t     pcv;
    logic [AGE_W-1:0]     pca;
    smf_pkg::sample_t     nv;
    logic [AGE_W-1:0]     na;

    if (i == 0) begin : g_lo
      assign pf  = '0;
      assign pcv = '0;
      assign pca = '0;
    end else begin : g_mid_lo
      assign pf  = cell_flags[i-1];
      assign pcv = cell_cval[i-1];
      assign pca = cell_cage[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_hi
      assign nf = '0;
      assign nv = '0;
      assign na = '0;
    end else begin : g_mid_hi
      assign nf = cell_flags[i+1];
      assign nv = cell_value[i+1];
      assign na = cell_age[i+1];
    end

    assign act_vec[i] = LEN_W'(i) < len;
    assign del_vec[i] = cell_flags[i].del;

    smf_cell #(
      .AGE_W(AGE_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .clear       (cfg_we),
      .step        (s_xfer),
      .new_sample  (new_sample),
      .init_age    (AGE_W'(i)),
      .len_m1      (len_m1),
      .active      (act_vec[i]),
      .last_active (len_m1 == AGE_W'(i)),
      .first       (i == 0),
      .prev_flags  (pf),
      .prev_c_value(pcv),
      .prev_c_age  (pca),
      .next_flags  (nf),
      .next_value  (nv),
      .next_age    (na),
      .flags       (cell_flags[i]),
      .value       (cell_value[i]),
      .age         (cell_age[i]),
      .c_value     (cell_cval[i]),
      .c_age       (cell_cage[i])
    );
  end

  // Exactly one cell inside the window holds the oldest sample.
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    $onehot(del_vec & act_vec))
    else $error("window does not hold exactly one oldest sample");

  // An accepted sample is waiting in the cells on the next cycle.
  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    s_xfer && !cfg_we |=> pend)
    else $error("accepted sample did not become pending");

  // A pending sample that cannot move to the output stays pending.
  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend && !load && !cfg_we |=> pend)
    else $error("pending sample was lost");

  // Loading the output register always offers a median.
  a_load_offers: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("output register loaded without valid");

  // No new sample while one is pending and the output is blocked.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    pend && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while the output path is full");

endmodule

[hw/rtl/smf_cell.sv]
// ----------------------------------------------------------------------------
// smf_cell: one place of the sorted window
// Holds one sample and its age. On a step the cell drops or keeps its value,
// takes the neighbor's value or the new sample, so that the row stays sorted.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int AGE_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,        // length register written
  input  logic                 step,         // a sample transfer happens
  input  smf_pkg::sample_t     new_sample,
  input  logic [AGE_W-1:0]     init_age,     // age given at clear
  input  logic [AGE_W-1:0]     len_m1,       // window length minus one
  input  logic                 active,       // cell lies inside the window
  input  logic                 last_active,  // cell is the top of the window
  input  logic                 first,        // cell is the bottom of the row
  input  smf_pkg::cell_flags_t prev_flags,
  input  smf_pkg::sample_t     prev_c_value,
  input  logic [AGE_W-1:0]     prev_c_age,
  input  smf_pkg::cell_flags_t next_flags,
  input  smf_pkg::sample_t     next_value,
  input  logic [AGE_W-1:0]     next_age,
  output smf_pkg::cell_flags_t flags,
  output smf_pkg::sample_t     value,
  output logic [AGE_W-1:0]     age,
  output smf_pkg::sample_t     c_value,
  output logic [AGE_W-1:0]     c_age
);

  smf_pkg::sample_t value_next;
  logic [AGE_W-1:0] age_next;

  // Flags: compare against the new sample and locate the oldest entry.
  always_comb begin
    flags.lt  = value < new_sample;
    flags.del = active && (age == len_m1);
    flags.rem = prev_flags.rem || flags.del;
    flags.cl  = !last_active && (flags.rem ? next_flags.lt : flags.lt);
  end

  // Value at this place once the oldest entry has been taken out.
  assign c_value = flags.rem ? next_value : value;
  assign c_age   = flags.rem ? next_age : age;

  // Insert the new sample where the compacted row crosses it.
  always_comb begin
    priority if (flags.cl) begin
      value_next = c_value;
      age_next   = c_age + 1'b1;
    end else if (first || prev_flags.cl) begin
      value_next = new_sample;
      age_next   = '0;
    end else begin
      value_next = prev_c_value;
      age_next   = prev_c_age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      value <= '0;
      age   <= init_age;
    end else if (step) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule
